### rtl/bhsa_pkg.sv
`default_nettype none

package bhsa_pkg;

  // Value format: signed Q16.16 in 32 bits.
  localparam int DATA_W = 32;
  typedef logic signed [DATA_W-1:0] data_t;

  localparam data_t DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam data_t DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // Stream widths.
  localparam int IN_TDATA_W  = 192;
  localparam int OUT_TDATA_W = 32;
  localparam int CMD_W       = 3;

  // Coordinate index width (3*atom+coord for a 5-bit atom).
  localparam int COL_W = 7;

  // Commands carried in tuser.
  localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ACC   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RD_S  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RD_Q  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RD_H  = 3'd4;

  // Store selected by one read-modify-write.
  localparam logic [1:0] TGT_S = 2'd0;
  localparam logic [1:0] TGT_Q = 2'd1;
  localparam logic [1:0] TGT_H = 2'd2;

  // Read-modify-write steps of one accumulate transaction.
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_S    = 3'd0;
  localparam logic [OP_W-1:0] OP_Q    = 3'd1;
  localparam logic [OP_W-1:0] OP_H0   = 3'd2;
  localparam logic [OP_W-1:0] OP_LAST = 3'd7;

  // Operands of the shared saturating adder.
  typedef struct packed {
    logic  sub;
    data_t a;
    data_t b;
  } alu_op_t;

endpackage

`default_nettype wire

### rtl/bhsa_sat_alu.sv
`default_nettype none

// Saturating add or subtract on signed 32-bit values.
module bhsa_sat_alu (
  input  wire bhsa_pkg::alu_op_t op_i,
  output bhsa_pkg::data_t        res_o
);

  logic signed [bhsa_pkg::DATA_W:0] a_x;
  logic signed [bhsa_pkg::DATA_W:0] b_x;
  logic signed [bhsa_pkg::DATA_W:0] sum;

  // One extra bit holds every exact sum or difference.
  always_comb begin
    a_x = {op_i.a[bhsa_pkg::DATA_W-1], op_i.a};
    b_x = {op_i.b[bhsa_pkg::DATA_W-1], op_i.b};
    sum = op_i.sub ? (a_x - b_x) : (a_x + b_x);
  end

  // Clamp when the top two bits disagree.
  always_comb begin
    if (sum[bhsa_pkg::DATA_W] != sum[bhsa_pkg::DATA_W-1]) begin
      res_o = sum[bhsa_pkg::DATA_W] ? bhsa_pkg::DATA_MIN : bhsa_pkg::DATA_MAX;
    end else begin
      res_o = sum[bhsa_pkg::DATA_W-1:0];
    end
  end

endmodule

`default_nettype wire

### rtl/bhsa_ram.sv
`default_nettype none

// Simple dual-port memory: one write port, one read port with registered data.
module bhsa_ram #(
  parameter int DEPTH = 768,
  parameter int WIDTH = 32,
  parameter int AW    = 10
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port; data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

### rtl/bond_hessian_scatter_add_core.sv
`default_nettype none

// Per-type scatter-add of bond energy sums S, gradients Q and Hessians H.
// Input stream (s_axis): one transaction is one command in tuser with its
// operands in tdata. Commands clear all stores, accumulate one bond row
// (saturating read-modify-writes of S for row 0 only, Q, three off-diagonal
// and three diagonal H entries) or read one entry. Output stream (m_axis):
// one transaction per read command carrying the entry.
// Timing: a single saturating adder is shared by all updates, each applied
// in the cycle after its read. An accumulate occupies the block for two
// address steps, eight update steps and one write drain; a read passes
// through the two address steps, a store read and an output step, and the
// block is ready again in the same cycle as its value is presented. The
// Hessian row address needs two constant multiplies, one per step.
// A clear, and reset, starts a clearing pass through the Hessian memory
// (the gradient memory is cleared alongside), MAX_TYPES*(3*MAX_ATOMS)^2
// entries, 73728 at the defaults; s_axis_tready stays low meanwhile.
// A result waits in the output register while the receiver stalls; the
// next transaction is still accepted, and only a second read result waits
// for the register to empty.
module bond_hessian_scatter_add_core #(
  parameter int MAX_TYPES = 8,
  parameter int MAX_ATOMS = 32
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Input stream.
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // tdata from bit 0: pair_type[2:0], atom_u[7:3], atom_v[12:8], row_k[14:13],
  // s_value[46:15], q_value[78:47], h_0[110:79], h_1[142:111],
  // h_2[174:143], read_row[181:175], read_col[188:182], zeros[191:189]
  input  wire logic [bhsa_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // tuser from bit 0: cmd[2:0]
  input  wire logic [bhsa_pkg::CMD_W-1:0]         s_axis_tuser,
  // Output stream.
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // tdata from bit 0: read_value[31:0]
  output logic      [bhsa_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

  localparam int DIMS   = 3 * MAX_ATOMS;
  localparam int QDEPTH = MAX_TYPES * DIMS;
  localparam int HDEPTH = QDEPTH * DIMS;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int HAW    = $clog2(HDEPTH);
  localparam int TW     = (MAX_TYPES > 1) ? $clog2(MAX_TYPES) : 1;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_IDX   = 3'd2;
  localparam logic [2:0] ST_ROW   = 3'd3;
  localparam logic [2:0] ST_ACC   = 3'd4;
  localparam logic [2:0] ST_DRAIN = 3'd5;
  localparam logic [2:0] ST_RDREQ = 3'd6;
  localparam logic [2:0] ST_OUT   = 3'd7;

  logic [2:0] state_q, state_d;
  logic       in_fire;

  // Captured transaction.
  logic [bhsa_pkg::CMD_W-1:0] cmd_q;
  logic [2:0]                 t_q;
  logic [4:0]                 u_q;
  logic [4:0]                 v_q;
  logic [1:0]                 k_q;
  bhsa_pkg::data_t            s_val_q;
  bhsa_pkg::data_t            q_val_q;
  bhsa_pkg::data_t            h_val_q [3];
  logic [bhsa_pkg::COL_W-1:0] r_q;
  logic [bhsa_pkg::COL_W-1:0] c_q;

  // Address steps.
  logic [bhsa_pkg::COL_W-1:0] u3, v3, row_sel;
  logic [bhsa_pkg::COL_W-1:0] u3_q, v3_q;
  logic [QAW-1:0]             rq_q;
  logic [HAW-1:0]             hrow_q;
  logic                       acc_ok, rd_ok, rd_ok_q;
  logic [TW-1:0]              tix;

  // Update sequencer.
  logic [bhsa_pkg::OP_W-1:0]  op_q;
  logic [1:0]                 acc_tgt;
  logic                       acc_en;
  logic                       acc_sub;
  bhsa_pkg::data_t            acc_b;
  logic [1:0]                 lsel;
  logic [bhsa_pkg::COL_W-1:0] acc_col, col_sel;

  // Pending write, issued in the cycle after its read.
  logic                       pend_q;
  logic [1:0]                 pend_tgt_q;
  logic [HAW-1:0]             pend_addr_q;
  logic                       pend_sub_q;
  bhsa_pkg::data_t            pend_b_q;
  bhsa_pkg::alu_op_t          alu_op;
  bhsa_pkg::data_t            alu_res;

  // Stores.
  bhsa_pkg::data_t            s_q [MAX_TYPES];
  bhsa_pkg::data_t            s_rd_q;
  logic [HAW-1:0]             clr_cnt_q;
  logic                       clearing;
  logic                       q_we, q_re, h_we, h_re;
  logic [QAW-1:0]             q_waddr;
  logic [HAW-1:0]             h_raddr;
  bhsa_pkg::data_t            store_wdata;
  logic [bhsa_pkg::DATA_W-1:0] q_rdata, h_rdata;

  // Output register.
  logic                       out_valid_q, out_valid_d;
  bhsa_pkg::data_t            out_data_q, rd_value;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign clearing      = (state_q == ST_CLEAR);
  assign tix           = TW'(t_q);

  // Capture the transaction fields.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q      <= s_axis_tuser;
      t_q        <= s_axis_tdata[2:0];
      u_q        <= s_axis_tdata[7:3];
      v_q        <= s_axis_tdata[12:8];
      k_q        <= s_axis_tdata[14:13];
      s_val_q    <= s_axis_tdata[46:15];
      q_val_q    <= s_axis_tdata[78:47];
      h_val_q[0] <= s_axis_tdata[110:79];
      h_val_q[1] <= s_axis_tdata[142:111];
      h_val_q[2] <= s_axis_tdata[174:143];
      r_q        <= s_axis_tdata[181:175];
      c_q        <= s_axis_tdata[188:182];
    end
  end

  // Range checks and the row index 3u+k (or read_row).
  always_comb begin
    u3      = (bhsa_pkg::COL_W'(u_q) << 1) + bhsa_pkg::COL_W'(u_q);
    v3      = (bhsa_pkg::COL_W'(v_q) << 1) + bhsa_pkg::COL_W'(v_q);
    row_sel = (cmd_q == bhsa_pkg::CMD_ACC) ? (u3 + bhsa_pkg::COL_W'(k_q)) : r_q;
    acc_ok  = (32'(t_q) < MAX_TYPES) && (32'(u_q) < MAX_ATOMS) &&
              (32'(v_q) < MAX_ATOMS) && (k_q != 2'd3) && (u_q != v_q);
    rd_ok   = 1'b0;
    case (cmd_q)
      bhsa_pkg::CMD_RD_S: rd_ok = (32'(t_q) < MAX_TYPES);
      bhsa_pkg::CMD_RD_Q: rd_ok = (32'(t_q) < MAX_TYPES) && (32'(r_q) < DIMS);
      bhsa_pkg::CMD_RD_H: rd_ok = (32'(t_q) < MAX_TYPES) && (32'(r_q) < DIMS) &&
                                  (32'(c_q) < DIMS);
      default:            rd_ok = 1'b0;
    endcase
  end

  // Address registers: plane row first, then the Hessian row base.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDX) begin
      u3_q    <= u3;
      v3_q    <= v3;
      rd_ok_q <= rd_ok;
      rq_q    <= QAW'(t_q) * QAW'(DIMS) + QAW'(row_sel);
    end
    if (state_q == ST_ROW) begin
      hrow_q <= HAW'(rq_q) * HAW'(DIMS);
    end
  end

  // Decode of the current update step.
  always_comb begin
    lsel    = 2'((op_q - bhsa_pkg::OP_H0) >> 1);
    acc_col = (op_q[0] ? u3_q : v3_q) + bhsa_pkg::COL_W'(lsel);
    acc_tgt = bhsa_pkg::TGT_H;
    acc_en  = 1'b1;
    acc_sub = ~op_q[0];
    case (lsel)
      2'd1:    acc_b = h_val_q[1];
      2'd2:    acc_b = h_val_q[2];
      default: acc_b = h_val_q[0];
    endcase
    unique case (op_q)
      bhsa_pkg::OP_S: begin
        acc_tgt = bhsa_pkg::TGT_S;
        acc_en  = (k_q == 2'd0);
        acc_sub = 1'b0;
        acc_b   = s_val_q;
      end
      bhsa_pkg::OP_Q: begin
        acc_tgt = bhsa_pkg::TGT_Q;
        acc_sub = 1'b0;
        acc_b   = q_val_q;
      end
      default: begin
      end
    endcase
  end

  // Read side of the stores.
  assign col_sel = (state_q == ST_ACC) ? acc_col : c_q;
  assign h_raddr = hrow_q + HAW'(col_sel);
  assign q_re    = ((state_q == ST_ACC) && (op_q == bhsa_pkg::OP_Q)) ||
                   ((state_q == ST_RDREQ) && (cmd_q == bhsa_pkg::CMD_RD_Q));
  assign h_re    = ((state_q == ST_ACC) && (acc_tgt == bhsa_pkg::TGT_H)) ||
                   ((state_q == ST_RDREQ) && (cmd_q == bhsa_pkg::CMD_RD_H));

  always_ff @(posedge clk_i) begin
    if (((state_q == ST_ACC) && (op_q == bhsa_pkg::OP_S)) ||
        ((state_q == ST_RDREQ) && (cmd_q == bhsa_pkg::CMD_RD_S))) begin
      s_rd_q <= s_q[tix];
    end
  end

  // Pending write payload.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_ACC) begin
      pend_tgt_q  <= acc_tgt;
      pend_addr_q <= (acc_tgt == bhsa_pkg::TGT_Q) ? HAW'(rq_q) : h_raddr;
      pend_sub_q  <= acc_sub;
      pend_b_q    <= acc_b;
    end
  end

  // Shared saturating adder.
  always_comb begin
    alu_op.sub = pend_sub_q;
    alu_op.b   = pend_b_q;
    case (pend_tgt_q)
      bhsa_pkg::TGT_S: alu_op.a = s_rd_q;
      bhsa_pkg::TGT_Q: alu_op.a = q_rdata;
      default:         alu_op.a = h_rdata;
    endcase
  end

  bhsa_sat_alu u_alu (
    .op_i  (alu_op),
    .res_o (alu_res)
  );

  // Write side: clearing pass or the pending update.
  assign store_wdata = clearing ? '0 : alu_res;
  assign q_we    = (clearing && (clr_cnt_q < HAW'(QDEPTH))) ||
                   (pend_q && (pend_tgt_q == bhsa_pkg::TGT_Q));
  assign q_waddr = clearing ? QAW'(clr_cnt_q) : QAW'(pend_addr_q);
  assign h_we    = clearing || (pend_q && (pend_tgt_q == bhsa_pkg::TGT_H));

  bhsa_ram #(
    .DEPTH (QDEPTH),
    .WIDTH (bhsa_pkg::DATA_W),
    .AW    (QAW)
  ) u_q_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (store_wdata),
    .re_i    (q_re),
    .raddr_i (rq_q),
    .rdata_o (q_rdata)
  );

  bhsa_ram #(
    .DEPTH (HDEPTH),
    .WIDTH (bhsa_pkg::DATA_W),
    .AW    (HAW)
  ) u_h_ram (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (clearing ? clr_cnt_q : pend_addr_q),
    .wdata_i (store_wdata),
    .re_i    (h_re),
    .raddr_i (h_raddr),
    .rdata_o (h_rdata)
  );

  // Read result, zero for an index out of range.
  always_comb begin
    rd_value = '0;
    if (rd_ok_q) begin
      case (cmd_q)
        bhsa_pkg::CMD_RD_S: rd_value = s_rd_q;
        bhsa_pkg::CMD_RD_Q: rd_value = q_rdata;
        default:            rd_value = h_rdata;
      endcase
    end
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_cnt_q == HAW'(HDEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          state_d = (s_axis_tuser == bhsa_pkg::CMD_CLEAR) ? ST_CLEAR : ST_IDX;
        end
      end
      ST_IDX: begin
        case (cmd_q) inside
          bhsa_pkg::CMD_ACC:
            state_d = acc_ok ? ST_ROW : ST_IDLE;
          bhsa_pkg::CMD_RD_S, bhsa_pkg::CMD_RD_Q, bhsa_pkg::CMD_RD_H:
            state_d = ST_ROW;
          default:
            state_d = ST_IDLE;
        endcase
      end
      ST_ROW:   state_d = (cmd_q == bhsa_pkg::CMD_ACC) ? ST_ACC : ST_RDREQ;
      ST_ACC:   state_d = (op_q == bhsa_pkg::OP_LAST) ? ST_DRAIN : ST_ACC;
      ST_DRAIN: state_d = ST_IDLE;
      ST_RDREQ: state_d = ST_OUT;
      ST_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // Output handshake: load on a finished read, drop when taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if ((state_q == ST_OUT) && (!out_valid_q || m_axis_tready)) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_OUT) && (!out_valid_q || m_axis_tready)) begin
      out_data_q <= rd_value;
    end
  end

  // Control registers and the scalar store.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      op_q        <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < MAX_TYPES; i++) begin
        s_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      pend_q      <= (state_q == ST_ACC) && acc_en;
      if (clearing) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (in_fire && (s_axis_tuser == bhsa_pkg::CMD_CLEAR)) begin
        clr_cnt_q <= '0;
        for (int i = 0; i < MAX_TYPES; i++) begin
          s_q[i] <= '0;
        end
      end
      if (state_q == ST_ACC) begin
        op_q <= op_q + 1'b1;
      end else begin
        op_q <= '0;
      end
      if (pend_q && (pend_tgt_q == bhsa_pkg::TGT_S)) begin
        s_q[tix] <= alu_res;
      end
    end
  end

endmodule

`default_nettype wire

### tb/bond_hessian_scatter_add_core_tb.sv
module bond_hessian_scatter_add_core_tb;

  // Geometry of the instance under test (default parameters).
  localparam int N_TYPES = 8;
  localparam int N_ATOMS = 32;
  localparam int N_DIMS  = 3 * N_ATOMS;

  // Commands that the block ignores and the row code that it rejects.
  localparam logic [bhsa_pkg::CMD_W-1:0] CMD_SPARE_LO = 3'd5;
  localparam logic [bhsa_pkg::CMD_W-1:0] CMD_SPARE_HI = 3'd7;
  localparam logic [1:0]                 ROW_BAD      = 2'd3;

  // A clear pass holds tready low while it walks all N_TYPES*N_DIMS^2 Hessian entries; allow it four times over.
  localparam int STALL_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 24;

  // One input transaction, unpacked.
  typedef struct {
    logic [bhsa_pkg::CMD_W-1:0] cmd;
    logic [2:0]                 pair_type;
    logic [4:0]                 atom_u;
    logic [4:0]                 atom_v;
    logic [1:0]                 row_k;
    bhsa_pkg::data_t            s_value;
    bhsa_pkg::data_t            q_value;
    bhsa_pkg::data_t            h_0;
    bhsa_pkg::data_t            h_1;
    bhsa_pkg::data_t            h_2;
    logic [6:0]                 read_row;
    logic [6:0]                 read_col;
  } bond_cmd_t;

  logic                             clk_i;
  logic                             rst_ni;
  logic                             s_axis_tvalid;
  logic                             s_axis_tready;
  logic [bhsa_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
  logic [bhsa_pkg::CMD_W-1:0]       s_axis_tuser;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready;
  logic [bhsa_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

  // Shadow copies of the three stores.
  bhsa_pkg::data_t scalar_acc [N_TYPES];
  bhsa_pkg::data_t grad_acc   [N_TYPES * N_DIMS];
  bhsa_pkg::data_t hess_acc   [N_TYPES * N_DIMS * N_DIMS];

  // Read values still owed by the block, oldest first.
  bhsa_pkg::data_t pending_reads [$];
  bhsa_pkg::data_t oldest_read;

  int mismatches = 0;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int quiet_cycles = 0;

  bond_hessian_scatter_add_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock with a period of 4.
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Saturating add or subtract in Q16.16.
  function automatic bhsa_pkg::data_t sat_sum(input bhsa_pkg::data_t a,
                                              input bhsa_pkg::data_t b,
                                              input bit negate);
    longint r;
    r = negate ? longint'(a) - longint'(b) : longint'(a) + longint'(b);
    if (r > longint'(bhsa_pkg::DATA_MAX)) return bhsa_pkg::DATA_MAX;
    if (r < longint'(bhsa_pkg::DATA_MIN)) return bhsa_pkg::DATA_MIN;
    return bhsa_pkg::data_t'(r);
  endfunction

  function automatic void clear_stores();
    foreach (scalar_acc[i]) scalar_acc[i] = '0;
    foreach (grad_acc[i]) grad_acc[i] = '0;
    foreach (hess_acc[i]) hess_acc[i] = '0;
  endfunction

  // Updates the shadow stores for one accepted transaction and queues any read value.
  function automatic void predict_stores(input bond_cmd_t c);
    int t, u, v, row, base, col;
    bhsa_pkg::data_t hv [3];
    bhsa_pkg::data_t val;
    t = int'(c.pair_type);
    u = int'(c.atom_u);
    v = int'(c.atom_v);
    row = int'(c.read_row);
    col = int'(c.read_col);
    hv[0] = c.h_0;
    hv[1] = c.h_1;
    hv[2] = c.h_2;
    val = '0;
    case (c.cmd)
      bhsa_pkg::CMD_CLEAR: clear_stores();
      bhsa_pkg::CMD_ACC: begin
        if (t < N_TYPES && u < N_ATOMS && v < N_ATOMS && c.row_k != ROW_BAD && u != v) begin
          if (c.row_k == 2'd0) scalar_acc[t] = sat_sum(scalar_acc[t], c.s_value, 1'b0);
          row = 3 * u + int'(c.row_k);
          grad_acc[t * N_DIMS + row] = sat_sum(grad_acc[t * N_DIMS + row], c.q_value, 1'b0);
          base = (t * N_DIMS + row) * N_DIMS;
          for (int l = 0; l < 3; l++) begin
            hess_acc[base + 3 * v + l] = sat_sum(hess_acc[base + 3 * v + l], hv[l], 1'b1);
            hess_acc[base + 3 * u + l] = sat_sum(hess_acc[base + 3 * u + l], hv[l], 1'b0);
          end
        end
      end
      bhsa_pkg::CMD_RD_S: begin
        if (t < N_TYPES) val = scalar_acc[t];
        pending_reads.insert(pending_reads.size(), val);
      end
      bhsa_pkg::CMD_RD_Q: begin
        if (t < N_TYPES && row < N_DIMS) val = grad_acc[t * N_DIMS + row];
        pending_reads.insert(pending_reads.size(), val);
      end
      bhsa_pkg::CMD_RD_H: begin
        if (t < N_TYPES && row < N_DIMS && col < N_DIMS)
          val = hess_acc[(t * N_DIMS + row) * N_DIMS + col];
        pending_reads.insert(pending_reads.size(), val);
      end
      default: ;
    endcase
  endfunction

  // Drives one transaction with random idle cycles ahead of it and waits for acceptance.
  task automatic send_cmd(input bond_cmd_t c);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= c.cmd;
    s_axis_tdata  <= {3'b000, c.read_col, c.read_row, c.h_2, c.h_1, c.h_0, c.q_value,
                      c.s_value, c.row_k, c.atom_v, c.atom_u, c.pair_type};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_stores(c);
  endtask

  task automatic send_bond(input logic [2:0] t, input logic [4:0] u, input logic [4:0] v,
                           input logic [1:0] k, input bhsa_pkg::data_t s,
                           input bhsa_pkg::data_t q, input bhsa_pkg::data_t h0,
                           input bhsa_pkg::data_t h1, input bhsa_pkg::data_t h2);
    bond_cmd_t c;
    c = '{bhsa_pkg::CMD_ACC, t, u, v, k, s, q, h0, h1, h2, 7'd0, 7'd0};
    send_cmd(c);
  endtask

  task automatic send_query(input logic [bhsa_pkg::CMD_W-1:0] cmd, input logic [2:0] t,
                            input logic [6:0] row, input logic [6:0] col);
    bond_cmd_t c;
    c = '{cmd, t, 5'd0, 5'd0, 2'd0, '0, '0, '0, '0, '0, row, col};
    send_cmd(c);
  endtask

  // Lowers tvalid, waits until every read value has come back, then waits out the DRAIN_CYCLES margin.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Mostly a few atoms so that bonds land on the same entries; sometimes any atom.
  function automatic logic [4:0] pick_atom();
    if ($urandom_range(3) == 0) return 5'($urandom_range(N_ATOMS - 1));
    return 5'($urandom_range(3));
  endfunction

  function automatic logic [6:0] pick_index();
    if ($urandom_range(4) == 0) return 7'($urandom_range(127));
    return 7'(3 * int'(pick_atom()) + int'($urandom_range(2)));
  endfunction

  function automatic bhsa_pkg::data_t pick_value();
    case ($urandom_range(5))
      0: return bhsa_pkg::data_t'($urandom_range(32'h0002_0000)) *
                ($urandom_range(1) ? -1 : 1);
      1: return bhsa_pkg::DATA_MAX;
      2: return bhsa_pkg::DATA_MIN;
      default: return bhsa_pkg::data_t'($urandom);
    endcase
  endfunction

  function automatic bond_cmd_t pick_cmd();
    bond_cmd_t c;
    int sel;
    c.pair_type = $urandom_range(1) ? 3'($urandom_range(1)) : 3'($urandom_range(N_TYPES - 1));
    c.atom_u = pick_atom();
    c.atom_v = pick_atom();
    if (c.atom_u == c.atom_v && $urandom_range(3) != 0) c.atom_v = c.atom_u ^ 5'd1;
    c.row_k = ($urandom_range(19) == 0) ? ROW_BAD : 2'($urandom_range(2));
    c.s_value = pick_value();
    c.q_value = pick_value();
    c.h_0 = pick_value();
    c.h_1 = pick_value();
    c.h_2 = pick_value();
    c.read_row = pick_index();
    c.read_col = pick_index();
    sel = $urandom_range(99);
    if (sel < 55) c.cmd = bhsa_pkg::CMD_ACC;
    else if (sel < 63) c.cmd = bhsa_pkg::CMD_RD_S;
    else if (sel < 75) c.cmd = bhsa_pkg::CMD_RD_Q;
    else if (sel < 96) c.cmd = bhsa_pkg::CMD_RD_H;
    else c.cmd = 3'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
    return c;
  endfunction

  // Reads after reset must all return zero.
  task automatic test_after_reset();
    send_query(bhsa_pkg::CMD_RD_S, 3'd0, 7'd0, 7'd0);
    send_query(bhsa_pkg::CMD_RD_Q, 3'd7, 7'd95, 7'd0);
    send_query(bhsa_pkg::CMD_RD_H, 3'd3, 7'd40, 7'd95);
  endtask

  // Row 0 and row 2 of one bond, then the scalar, the row-0 gradient and one Hessian entry of each row.
  task automatic test_bond_rows();
    send_bond(3'd2, 5'd1, 5'd5, 2'd0, 32'h0001_8000, 32'hFFFF_0000,
              32'h0000_4000, 32'h0002_0000, 32'hFFFE_0000);
    send_bond(3'd2, 5'd1, 5'd5, 2'd2, 32'h0003_0000, 32'h0000_1000,
              32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000);
    send_query(bhsa_pkg::CMD_RD_S, 3'd2, 7'd0, 7'd0);
    send_query(bhsa_pkg::CMD_RD_Q, 3'd2, 7'd3, 7'd0);
    send_query(bhsa_pkg::CMD_RD_H, 3'd2, 7'd5, 7'd16);
    send_query(bhsa_pkg::CMD_RD_H, 3'd2, 7'd3, 7'd4);
  endtask

  // Extreme values twice on the same entries drive every sum into saturation.
  task automatic test_saturation();
    repeat (2) send_bond(3'd7, 5'd31, 5'd0, 2'd0, bhsa_pkg::DATA_MAX, bhsa_pkg::DATA_MAX,
                         bhsa_pkg::DATA_MAX, bhsa_pkg::DATA_MIN, bhsa_pkg::DATA_MAX);
    send_query(bhsa_pkg::CMD_RD_S, 3'd7, 7'd0, 7'd0);
    send_query(bhsa_pkg::CMD_RD_Q, 3'd7, 7'd93, 7'd0);
    send_query(bhsa_pkg::CMD_RD_H, 3'd7, 7'd93, 7'd0);
    send_query(bhsa_pkg::CMD_RD_H, 3'd7, 7'd93, 7'd94);
  endtask

  // Self bonds, the invalid row and spare commands change nothing; bad indexes read zero.
  task automatic test_ignored();
    send_bond(3'd2, 5'd4, 5'd4, 2'd0, bhsa_pkg::DATA_MAX, bhsa_pkg::DATA_MAX,
              bhsa_pkg::DATA_MAX, bhsa_pkg::DATA_MAX, bhsa_pkg::DATA_MAX);
    send_bond(3'd2, 5'd1, 5'd5, ROW_BAD, bhsa_pkg::DATA_MAX, bhsa_pkg::DATA_MAX,
              bhsa_pkg::DATA_MAX, bhsa_pkg::DATA_MAX, bhsa_pkg::DATA_MAX);
    for (logic [bhsa_pkg::CMD_W-1:0] op = CMD_SPARE_LO;
         op <= CMD_SPARE_HI && op >= CMD_SPARE_LO; op++) begin
      send_query(op, 3'd2, 7'd3, 7'd3);
    end
    send_query(bhsa_pkg::CMD_RD_S, 3'd2, 7'd0, 7'd0);
    send_query(bhsa_pkg::CMD_RD_Q, 3'd2, 7'd96, 7'd0);
    send_query(bhsa_pkg::CMD_RD_H, 3'd2, 7'd3, 7'd127);
  endtask

  // A clear wipes the stores; the block stalls for the clearing pass.
  task automatic test_clear();
    send_query(bhsa_pkg::CMD_CLEAR, 3'd0, 7'd0, 7'd0);
    send_query(bhsa_pkg::CMD_RD_H, 3'd7, 7'd93, 7'd0);
  endtask

  // Random traffic: the given number of transactions under the given idle and stall rates.
  task automatic test_random(input int n_items, input int src_pct, input int sink_pct);
    bond_cmd_t c;
    src_idle_pct = src_pct;
    sink_stall_pct = sink_pct;
    repeat (n_items) begin
      c = pick_cmd();
      send_cmd(c);
    end
    drain();
  endtask

  // Output side: random stalls, and each read result against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_reads.size() == 0) begin
        mismatches++;
        $display("%0t: read_value expected none, actual %h", $time, m_axis_tdata);
      end else begin
        oldest_read = pending_reads.pop_front();
        if (m_axis_tdata !== oldest_read) begin
          mismatches++;
          $display("%0t: read_value expected %h, actual %h", $time, oldest_read, m_axis_tdata);
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Watchdog: ends the run when no transaction moves for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = bhsa_pkg::CMD_CLEAR;
    m_axis_tready = 1'b0;
    clear_stores();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_after_reset();
    test_bond_rows();
    test_saturation();
    test_ignored();
    test_clear();
    drain();

    test_random(190, 0, 0);
    test_random(190, 61, 0);
    test_clear();
    test_random(185, 0, 61);
    test_random(185, 33, 33);

    if (mismatches == 0 && pending_reads.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### sim.f
rtl/bhsa_pkg.sv
rtl/bhsa_sat_alu.sv
rtl/bhsa_ram.sv
rtl/bond_hessian_scatter_add_core.sv
tb/bond_hessian_scatter_add_core_tb.sv
